>>> src/pvi_pkg.sv
// Shared types, constants and codes for the particle Verlet integrator.
package pvi_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned DT_W     = 16;
    localparam int unsigned KE_W     = 48;
    localparam int unsigned SQ_W     = 64;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned S_DATA_W = 80;
    localparam int unsigned M_DATA_W = 176;

    localparam logic [WORD_W-1:0] MASS_RESET     = 32'h0001_0000;
    localparam logic [WORD_W-1:0] INV_MASS_RESET = 32'h0001_0000;
    localparam logic [KE_W-1:0]   KE_MAX         = {KE_W{1'b1}};

    typedef enum logic [IDX_W-1:0] {
        REG_MASS       = 3'd0,
        REG_INV_MASS   = 3'd1,
        REG_IS_STATIC  = 3'd2,
        REG_INIT_POS_X = 3'd3,
        REG_INIT_POS_Y = 3'd4,
        REG_INIT_VEL_X = 3'd5,
        REG_INIT_VEL_Y = 3'd6
    } reg_idx_t;

    typedef enum logic {
        REQ_FORCE = 1'b0,
        REQ_STEP  = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_SQ,
        ST_SUM,
        ST_EMUL,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic upd_en;
        logic sq_en;
        logic force_op;
        logic ld_pos;
        logic ld_vel;
    } lane_ctrl_t;

    typedef struct packed {
        logic sum_en;
        logic mul_en;
    } ke_ctrl_t;

endpackage

>>> src/pvi_lane.sv
// One axis of the particle: position, velocity, acceleration and their update.
module pvi_lane (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pvi_pkg::lane_ctrl_t         ctrl,
    input  logic [pvi_pkg::WORD_W-1:0]  force_in,
    input  logic [pvi_pkg::WORD_W-1:0]  inv_mass,
    input  logic [pvi_pkg::DT_W-1:0]    dt,
    input  logic [2*pvi_pkg::DT_W-1:0]  dt2,
    input  logic [pvi_pkg::WORD_W-1:0]  ld_data,
    output logic [pvi_pkg::WORD_W-1:0]  pos,
    output logic [pvi_pkg::WORD_W-1:0]  vel,
    output logic [pvi_pkg::SQ_W-1:0]    sq
);
    import pvi_pkg::*;

    logic [WORD_W-1:0] pos_reg, vel_reg, acc_reg;
    logic [WORD_W-1:0] pos_next, vel_next, acc_next;
    logic [WORD_W-1:0] wide_reg, vdt_reg, adt_reg;
    logic [SQ_W-1:0]   sq_reg;

    logic [WORD_W-1:0]      mul_a;
    logic [WORD_W:0]        mul_b;
    logic signed [2*WORD_W:0] p_wide;
    logic signed [WORD_W+DT_W:0] p_vdt, p_adt;
    logic signed [SQ_W-1:0] p_sq;
    logic [WORD_W-1:0]      wide_slice;

    // shared 32x33 multiplier: force*inv_mass or acc*dt^2
    always_comb begin
        mul_a  = ctrl.force_op ? force_in : acc_reg;
        mul_b  = ctrl.force_op ? {1'b0, inv_mass} : {1'b0, dt2};
        p_wide = (2*WORD_W+1)'($signed(mul_a)) * (2*WORD_W+1)'($signed(mul_b));
        p_vdt  = (WORD_W+DT_W+1)'($signed(vel_reg)) * (WORD_W+DT_W+1)'($signed({1'b0, dt}));
        p_adt  = (WORD_W+DT_W+1)'($signed(acc_reg)) * (WORD_W+DT_W+1)'($signed({1'b0, dt}));
        p_sq   = SQ_W'($signed(vel_reg)) * SQ_W'($signed(vel_reg));
        // floor by shift, then wrap to 32 bits
        wide_slice = ctrl.force_op ? p_wide[47:16] : p_wide[64:33];
    end

    always_comb begin
        pos_next = pos_reg;
        vel_next = vel_reg;
        acc_next = acc_reg;
        if (ctrl.ld_pos) begin
            pos_next = ld_data;
        end
        if (ctrl.ld_vel) begin
            vel_next = ld_data;
        end
        if (ctrl.upd_en) begin
            if (ctrl.force_op) begin
                acc_next = acc_reg + wide_reg;
            end else begin
                pos_next = pos_reg + vdt_reg + wide_reg;
                vel_next = vel_reg + adt_reg;
                acc_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            vel_reg <= '0;
            acc_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            wide_reg <= wide_slice;
            vdt_reg  <= p_vdt[47:16];
            adt_reg  <= p_adt[48:17];
        end
        if (ctrl.sq_en) begin
            sq_reg <= p_sq;
        end
    end

    assign pos = pos_reg;
    assign vel = vel_reg;
    assign sq  = sq_reg;

endmodule

>>> src/pvi_energy.sv
// Merge stage: kinetic energy from both lanes' squared velocities.
module pvi_energy (
    input  logic                       aclk,
    input  pvi_pkg::ke_ctrl_t          ctrl,
    input  logic [pvi_pkg::SQ_W-1:0]   sq_x,
    input  logic [pvi_pkg::SQ_W-1:0]   sq_y,
    input  logic [pvi_pkg::WORD_W-1:0] mass,
    output logic [pvi_pkg::KE_W-1:0]   ke
);
    import pvi_pkg::*;

    logic [SQ_W-1:0] sum_reg;
    logic [SQ_W-1:0] lo_reg, hi_reg;
    logic [SQ_W-1:0] tot;
    logic [SQ_W-2:0] e;

    always_ff @(posedge aclk) begin
        if (ctrl.sum_en) begin
            sum_reg <= sq_x + sq_y;
        end
        if (ctrl.mul_en) begin
            lo_reg <= SQ_W'(sum_reg[WORD_W-1:0]) * SQ_W'(mass);
            hi_reg <= SQ_W'(sum_reg[SQ_W-1:WORD_W]) * SQ_W'(mass);
        end
    end

    // floor(sum*mass / 2^33) from the two partial products
    always_comb begin
        tot = hi_reg + {{WORD_W{1'b0}}, lo_reg[SQ_W-1:WORD_W]};
        e   = tot[SQ_W-1:1];
        ke  = (|e[SQ_W-2:KE_W]) ? KE_MAX : e[KE_W-1:0];
    end

endmodule

>>> src/particle_verlet_integrator.sv
// Top level: config registers, sequencer, two axis lanes and energy merge.
//
//  channel  | dir | handshake          | contents
//  s_       | in  | s_tvalid/s_tready  | tuser req_type; tdata force_x, force_y, time_step
//  m_       | out | m_tvalid/m_tready  | tdata pos_x, pos_y, vel_x, vel_y, kinetic_energy
//  APB      | in  | psel/penable       | seven registers at byte address 4*index
//
// An item passes from the accepting edge through multiply, update, square, sum and the
// energy product (two partial products with mass) to the result register. A new
// transaction is taken only once the result is loaded and the sequencer is back in idle.
// One item is worked at a time; the next is taken while a result still waits.
// A stalled result holds the sequencer in its last step until m_tready.
// aresetn is synchronous; it resets state, config, lane pos/vel/acc and m_tvalid only.
module particle_verlet_integrator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pvi_pkg::S_DATA_W-1:0]  s_tdata,   // force_x, force_y, time_step
    input  logic                          s_tuser,   // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pvi_pkg::M_DATA_W-1:0]  m_tdata,   // pos_x, pos_y, vel_x, vel_y, energy
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pvi_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import pvi_pkg::*;

    // configuration
    logic [WORD_W-1:0] mass_reg, inv_mass_reg;
    logic              static_reg;
    logic [WORD_W-1:0] ipx_reg, ipy_reg, ivx_reg, ivy_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    // item capture
    logic              req_reg;
    logic [WORD_W-1:0] fx_reg, fy_reg;
    logic [DT_W-1:0]   dt_reg;
    logic [2*DT_W-1:0] dt2_reg;

    state_t     state_reg, state_next;
    lane_ctrl_t ctl_x, ctl_y;
    ke_ctrl_t   ke_ctl;
    logic       accept, out_load;

    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;
    logic [WORD_W-1:0]     pos_x, pos_y, vel_x, vel_y;
    logic [SQ_W-1:0]       sq_x, sq_y;
    logic [KE_W-1:0]       ke;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg     <= MASS_RESET;
            inv_mass_reg <= INV_MASS_RESET;
            static_reg   <= 1'b0;
            ipx_reg      <= '0;
            ipy_reg      <= '0;
            ivx_reg      <= '0;
            ivy_reg      <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MASS:       mass_reg     <= pwdata;
                REG_INV_MASS:   inv_mass_reg <= pwdata;
                REG_IS_STATIC:  static_reg   <= pwdata[0];
                REG_INIT_POS_X: ipx_reg      <= pwdata;
                REG_INIT_POS_Y: ipy_reg      <= pwdata;
                REG_INIT_VEL_X: ivx_reg      <= pwdata;
                REG_INIT_VEL_Y: ivy_reg      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MASS:       prdata = mass_reg;
            REG_INV_MASS:   prdata = inv_mass_reg;
            REG_IS_STATIC:  prdata = {31'd0, static_reg};
            REG_INIT_POS_X: prdata = ipx_reg;
            REG_INIT_POS_Y: prdata = ipy_reg;
            REG_INIT_VEL_X: prdata = ivx_reg;
            REG_INIT_VEL_Y: prdata = ivy_reg;
            default:        prdata = '0;
        endcase
    end

    assign accept = s_tvalid & s_tready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_tuser;
            fx_reg  <= s_tdata[31:0];
            fy_reg  <= s_tdata[63:32];
            dt_reg  <= s_tdata[79:64];
            dt2_reg <= (2*DT_W)'(s_tdata[79:64]) * (2*DT_W)'(s_tdata[79:64]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        out_load        = 1'b0;
        ctl_x           = '0;
        ke_ctl          = '0;
        ctl_x.force_op  = (req_reg == REQ_FORCE);
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                ctl_x.mul_en = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD: begin
                ctl_x.upd_en = ~static_reg;
                state_next   = ST_SQ;
            end
            ST_SQ: begin
                ctl_x.sq_en = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                ke_ctl.sum_en = 1'b1;
                state_next    = ST_EMUL;
            end
            ST_EMUL: begin
                ke_ctl.mul_en = 1'b1;
                state_next    = ST_FIN;
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        ctl_y        = ctl_x;
        ctl_x.ld_pos = cfg_wr && (cfg_idx == REG_INIT_POS_X);
        ctl_x.ld_vel = cfg_wr && (cfg_idx == REG_INIT_VEL_X);
        ctl_y.ld_pos = cfg_wr && (cfg_idx == REG_INIT_POS_Y);
        ctl_y.ld_vel = cfg_wr && (cfg_idx == REG_INIT_VEL_Y);
    end

    pvi_lane u_lane_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctl_x),
        .force_in (fx_reg),
        .inv_mass (inv_mass_reg),
        .dt       (dt_reg),
        .dt2      (dt2_reg),
        .ld_data  (pwdata),
        .pos      (pos_x),
        .vel      (vel_x),
        .sq       (sq_x)
    );

    pvi_lane u_lane_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctl_y),
        .force_in (fy_reg),
        .inv_mass (inv_mass_reg),
        .dt       (dt_reg),
        .dt2      (dt2_reg),
        .ld_data  (pwdata),
        .pos      (pos_y),
        .vel      (vel_y),
        .sq       (sq_y)
    );

    pvi_energy u_energy (
        .aclk (aclk),
        .ctrl (ke_ctl),
        .sq_x (sq_x),
        .sq_y (sq_y),
        .mass (mass_reg),
        .ke   (ke)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {ke, vel_y, vel_x, pos_y, pos_x};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> src/pvi_checker.sv
// Port-level checks for the particle Verlet integrator, bound to the top level.
module pvi_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [pvi_pkg::M_DATA_W-1:0] m_tdata
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time: s_tready stays low after a transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input taken while an item is in flight");

    // a new result comes only out of a busy spell
    a_rose_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an item in flight");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind particle_verlet_integrator pvi_checker u_pvi_checker (.*);
